// ===== src/pebu_pkg.sv =====
// ----------------------------------------------------------------------------
// pebu_pkg
// Shared types, register indexes and constants of the peak envelope builder.
// ----------------------------------------------------------------------------
package pebu_pkg;

    // Default and format constants
    localparam int MAX_CHANNELS_DEF = 8;
    localparam int CFG_DATA_W       = 17;
    localparam int CFG_INDEX_W      = 3;
    localparam int BLOCK_W          = 17;
    localparam int FRAME_W          = 32;
    localparam int SCALE_SHIFT      = 8;   // divide by 256

    localparam logic [1:0] PEAK_NARROW        = 2'd1;
    localparam logic [1:0] PEAK_WIDE          = 2'd2;
    localparam logic [1:0] SAMPLE_BYTES_ONE   = 2'd1;
    localparam logic [1:0] SAMPLE_BYTES_TWO   = 2'd2;
    localparam logic [1:0] POINTS_ONE         = 2'd1;
    localparam logic [1:0] POINTS_TWO         = 2'd2;
    localparam logic [BLOCK_W-1:0] BLOCK_FRAMES_RST = 17'd256;
    localparam logic [3:0] CHANNELS_RST       = 4'd2;

    localparam logic MODE_SAMPLE = 1'b0;
    localparam logic MODE_FLUSH  = 1'b1;

    // Configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] REG_SAMPLE_BYTES     = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_PEAK_WIDTH       = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_POINTS_PER_VALUE = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_BLOCK_FRAMES     = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_CHANNELS         = 3'd4;

    typedef struct packed {
        logic               mode;
        logic signed [15:0] sample;
    } sample_word_t;

    typedef struct packed {
        logic [15:0]        peak_value;
        logic [2:0]         channel;
        logic               negative_point;
        logic [FRAME_W-1:0] frame_number;
        logic               last;
    } peak_word_t;

    typedef enum logic [0:0] {
        ST_IDLE,
        ST_EMIT
    } state_t;

    // Controller to datapath
    typedef struct packed {
        logic accept;   // take the input word this cycle
        logic load;     // load next peak word into the output register
        logic finish;   // clear peaks and bump the frame count
    } ctrl_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic need_emit;   // the offered word closes a peak frame
        logic word_last;   // the pending peak word is the last of the frame
        logic out_free;    // output register can take a word
    } dp_status_t;

endpackage

// ===== src/peak_envelope_builder_unit.sv =====
// ----------------------------------------------------------------------------
// peak_envelope_builder_unit
// Timing: an audio word updates its channel's peaks in the accept cycle; the
// peak words of a frame follow the closing word, paced by the output register.
// Throughput: one input word per cycle while no burst runs; a closing word adds
// a burst of one peak word per cycle (channels or 2 x channels).
// Reset: async active low; peaks, counters and output valid clear, registers
// return to 16-bit audio, 16-bit peaks, two points, 256 frames, two channels.
// ----------------------------------------------------------------------------
module peak_envelope_builder_unit
    import pebu_pkg::*;
#(
    parameter int MAX_CHANNELS = MAX_CHANNELS_DEF
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    // configuration write port
    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    // audio words in
    input  logic                   sample_valid,
    output logic                   sample_ready,
    input  sample_word_t           sample_word,
    // peak words out
    output logic                   peak_valid,
    input  logic                   peak_ready,
    output peak_word_t             peak_word
);

    ctrl_cmd_t  cmd;
    dp_status_t status;

    // Controller: idle takes words, emit runs the burst of one peak frame.
    // Intake halts only while a frame is being emitted.
    pebu_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (sample_valid),
        .in_ready (sample_ready),
        .status   (status),
        .cmd      (cmd)
    );

    // Datapath: per-channel peaks in flip-flops with one shared read port,
    // channel and block position counters, frame count and the output
    // register that holds a peak word until the sink takes it.
    pebu_dp #(
        .MAX_CHANNELS (MAX_CHANNELS)
    ) u_dp
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_word   (sample_word),
        .cmd       (cmd),
        .status    (status),
        .out_valid (peak_valid),
        .out_ready (peak_ready),
        .out_word  (peak_word)
    );

endmodule

// ===== src/pebu_ctrl.sv =====
// ----------------------------------------------------------------------------
// pebu_ctrl
// Controller: takes input words, runs the emission burst of a peak frame.
// ----------------------------------------------------------------------------
module pebu_ctrl
    import pebu_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  dp_status_t status,
    output ctrl_cmd_t  cmd
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid && status.need_emit)
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (status.out_free && status.word_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        in_ready   = 1'b0;
        cmd.accept = 1'b0;
        cmd.load   = 1'b0;
        cmd.finish = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready   = 1'b1;
                cmd.accept = in_valid;
            end
            ST_EMIT:
            begin
                cmd.load   = status.out_free;
                cmd.finish = status.out_free && status.word_last;
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
    end

endmodule

// ===== src/pebu_dp.sv =====
// ----------------------------------------------------------------------------
// pebu_dp
// Datapath: configuration, per-channel peaks, counters and output register.
// ----------------------------------------------------------------------------
module pebu_dp
    import pebu_pkg::*;
#(
    parameter int MAX_CHANNELS = MAX_CHANNELS_DEF
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    input  sample_word_t           in_word,
    input  ctrl_cmd_t              cmd,
    output dp_status_t             status,
    output logic                   out_valid,
    input  logic                   out_ready,
    output peak_word_t             out_word
);

    localparam int IDX_W = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
    localparam int CNT_W = $clog2(MAX_CHANNELS + 1);
    localparam int CMP_W = (CNT_W > 4) ? CNT_W : 4;

    // Configuration registers
    logic [1:0]         sb_reg;
    logic [1:0]         pw_reg;
    logic [1:0]         ppv_reg;
    logic [BLOCK_W-1:0] bf_reg;
    logic [3:0]         chn_reg;

    // Peak state
    logic signed [15:0] pos_reg [MAX_CHANNELS];
    logic signed [15:0] neg_reg [MAX_CHANNELS];
    logic [IDX_W-1:0]   ch_reg;
    logic [BLOCK_W-1:0] bp_reg;
    logic [FRAME_W-1:0] fc_reg;

    // Emission pointer
    logic [IDX_W-1:0]   ec_reg;
    logic               pt_reg;

    // Output register
    logic               ov_reg;
    peak_word_t         ow_reg;

    logic [CMP_W-1:0]   chan_ext;
    logic [CNT_W-1:0]   n_act;
    logic [IDX_W-1:0]   n_m1;
    logic [IDX_W-1:0]   ch_eff;
    logic               frame_end;
    logic [BLOCK_W-1:0] bp_inc;
    logic               block_end;
    logic signed [15:0] s_val;
    logic [IDX_W-1:0]   rd_idx;
    logic signed [15:0] pos_rd;
    logic signed [15:0] neg_rd;
    logic [15:0]        pos_mag;
    logic [15:0]        neg_mag;
    logic               one_point;
    logic               scale;
    logic [15:0]        word_value;

    // Effective channel count: zero acts as one, clamp to the lane count
    always_comb
    begin
        chan_ext = CMP_W'(chn_reg);
        if (chan_ext == '0)
        begin
            n_act = CNT_W'(1);
        end
        else if (chan_ext > CMP_W'(MAX_CHANNELS))
        begin
            n_act = CNT_W'(MAX_CHANNELS);
        end
        else
        begin
            n_act = CNT_W'(chan_ext);
        end
    end

    assign n_m1      = IDX_W'(n_act - CNT_W'(1));
    assign ch_eff    = (CNT_W'(ch_reg) >= n_act) ? '0 : ch_reg;
    assign frame_end = (ch_eff == n_m1);
    assign bp_inc    = bp_reg + BLOCK_W'(1);
    assign block_end = (bp_inc >= bf_reg) || (bp_inc == '0);

    assign s_val = (sb_reg == SAMPLE_BYTES_ONE)
                 ? {{8{in_word.sample[7]}}, in_word.sample[7:0]}
                 : in_word.sample;

    assign one_point = (ppv_reg == POINTS_ONE);
    assign scale     = (sb_reg != SAMPLE_BYTES_ONE) && (pw_reg == PEAK_NARROW);

    // Single read port, shared by the update and the emission burst
    assign rd_idx = cmd.accept ? ch_eff : ec_reg;
    assign pos_rd = pos_reg[rd_idx];
    assign neg_rd = neg_reg[rd_idx];

    always_comb
    begin
        pos_mag = pos_rd;
        neg_mag = 16'(~neg_rd + 16'sd1);
        if (scale)
        begin
            pos_mag = pos_mag >> SCALE_SHIFT;
            neg_mag = neg_mag >> SCALE_SHIFT;
        end
        if (one_point)
        begin
            word_value = (pos_mag > neg_mag) ? pos_mag : neg_mag;
        end
        else
        begin
            word_value = pt_reg ? neg_mag : pos_mag;
        end
    end

    always_comb
    begin
        if (in_word.mode == MODE_FLUSH)
        begin
            status.need_emit = (bp_reg != '0) || (ch_reg != '0);
        end
        else
        begin
            status.need_emit = frame_end && block_end;
        end
        status.word_last = (ec_reg == n_m1) && (one_point || pt_reg);
        status.out_free  = !ov_reg || out_ready;
    end

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sb_reg  <= SAMPLE_BYTES_TWO;
            pw_reg  <= PEAK_WIDE;
            ppv_reg <= POINTS_TWO;
            bf_reg  <= BLOCK_FRAMES_RST;
            chn_reg <= CHANNELS_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_SAMPLE_BYTES:     sb_reg  <= cfg_data[1:0];
                REG_PEAK_WIDTH:       pw_reg  <= cfg_data[1:0];
                REG_POINTS_PER_VALUE: ppv_reg <= cfg_data[1:0];
                REG_BLOCK_FRAMES:     bf_reg  <= cfg_data[BLOCK_W-1:0];
                REG_CHANNELS:         chn_reg <= cfg_data[3:0];
                default:              sb_reg  <= sb_reg;
            endcase
        end
    end

    // Peaks and position counters
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < MAX_CHANNELS; i++)
            begin
                pos_reg[i] <= '0;
                neg_reg[i] <= '0;
            end
            ch_reg <= '0;
            bp_reg <= '0;
            fc_reg <= '0;
        end
        else if (cmd.finish)
        begin
            for (int i = 0; i < MAX_CHANNELS; i++)
            begin
                pos_reg[i] <= '0;
                neg_reg[i] <= '0;
            end
            fc_reg <= fc_reg + FRAME_W'(1);
        end
        else if (cmd.accept)
        begin
            if (in_word.mode == MODE_FLUSH)
            begin
                // Empty flush: drop whatever is left, peaks stay for a burst
                if (!status.need_emit)
                begin
                    for (int i = 0; i < MAX_CHANNELS; i++)
                    begin
                        pos_reg[i] <= '0;
                        neg_reg[i] <= '0;
                    end
                end
                ch_reg <= '0;
                bp_reg <= '0;
            end
            else
            begin
                if (s_val > pos_rd)
                begin
                    pos_reg[ch_eff] <= s_val;
                end
                if (s_val < neg_rd)
                begin
                    neg_reg[ch_eff] <= s_val;
                end
                if (frame_end)
                begin
                    ch_reg <= '0;
                    bp_reg <= block_end ? '0 : bp_inc;
                end
                else
                begin
                    ch_reg <= ch_eff + IDX_W'(1);
                end
            end
        end
    end

    // Emission pointer: channel, then point within the channel
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ec_reg <= '0;
            pt_reg <= 1'b0;
        end
        else if (cmd.load)
        begin
            if (status.word_last)
            begin
                ec_reg <= '0;
                pt_reg <= 1'b0;
            end
            else if (one_point || pt_reg)
            begin
                ec_reg <= ec_reg + IDX_W'(1);
                pt_reg <= 1'b0;
            end
            else
            begin
                pt_reg <= 1'b1;
            end
        end
    end

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ov_reg <= 1'b0;
        end
        else if (cmd.load)
        begin
            ov_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            ov_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            ow_reg.peak_value     <= word_value;
            ow_reg.channel        <= 3'(ec_reg);
            ow_reg.negative_point <= !one_point && pt_reg;
            ow_reg.frame_number   <= fc_reg;
            ow_reg.last           <= status.word_last;
        end
    end

    assign out_valid = ov_reg;
    assign out_word  = ow_reg;

endmodule

// ===== src/pebu_checker.sv =====
// ----------------------------------------------------------------------------
// pebu_checker
// Port-level checks of the peak envelope builder, bound to the top level.
// ----------------------------------------------------------------------------
module pebu_checker
    import pebu_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         sample_ready,
    input  logic         peak_valid,
    input  logic         peak_ready,
    input  peak_word_t   peak_word
);

    // No peak word survives reset
    a_reset_clears: assert property (@(posedge clk)
        !rst_n |-> !peak_valid)
        else $error("peak word valid during reset");

    // A stalled peak word holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        peak_valid && !peak_ready |=> peak_valid && $stable(peak_word))
        else $error("peak word changed while stalled");

    // No intake while a peak frame is still being emitted
    a_no_intake_mid_frame: assert property (@(posedge clk) disable iff (!rst_n)
        peak_valid && !peak_word.last |-> !sample_ready)
        else $error("input taken in the middle of a peak frame");

    // Magnitude never exceeds the wrapped most negative sample
    a_value_range: assert property (@(posedge clk) disable iff (!rst_n)
        peak_valid |-> peak_word.peak_value <= 16'd32768)
        else $error("peak value out of range");

endmodule

bind peak_envelope_builder_unit pebu_checker u_pebu_checker
(
    .clk          (clk),
    .rst_n        (rst_n),
    .sample_ready (sample_ready),
    .peak_valid   (peak_valid),
    .peak_ready   (peak_ready),
    .peak_word    (peak_word)
);
